// File: src/lidar_reflector_segment_counter_top_assert.svh
// Assertion macros for the lidar reflector segment counter.
`ifndef LIDAR_REFLECTOR_SEGMENT_COUNTER_TOP_ASSERT_SVH
`define LIDAR_REFLECTOR_SEGMENT_COUNTER_TOP_ASSERT_SVH

// Checked on every rising edge while out of reset.
`define LRSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lrsc check failed");

// Checked on every rising edge, reset included.
`define LRSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lrsc check failed");

`endif

// File: src/lrsc_pkg.sv
// Package: types, constants and the arctangent table of the segment counter.
`default_nettype none
package lrsc_pkg;

  localparam int unsigned RangeW     = 16;
  localparam int unsigned AngleW     = 16;
  localparam int unsigned CountW     = 11;
  localparam int unsigned RunW       = 12;
  localparam int unsigned XyW        = 18;
  localparam int unsigned AccW       = 36;
  localparam int unsigned ZW         = 34;
  localparam int unsigned StageIdxW  = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned KinvQ16    = 39797;
  localparam int unsigned RunMax     = 4095;
  localparam int unsigned MaxStages  = 24;

  localparam int unsigned DefMaxBeams     = 2048;
  localparam int unsigned DefCordicStages = 16;

  localparam logic [CfgIdxW-1:0] RegStartAngle = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleStep  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegJoinDist   = 3'd3;

  typedef struct packed {
    logic [AngleW-1:0] start_angle;
    logic [AngleW-1:0] angle_step;
    logic [15:0]       threshold;
    logic [15:0]       join_dist;
  } cfg_t;

  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic [AngleW-1:0] angle;
    logic              high;
    logic              last;
  } beam_t;

  typedef enum logic [2:0] {
    StIdle,
    StRot,
    StRound,
    StSquare,
    StUpdate
  } back_state_e;

  function automatic logic [31:0] atan_turn(input logic [StageIdxW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/lidar_reflector_segment_counter_top.sv
// Top level of the lidar reflector segment counter.
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one word per lidar beam with
//    range_mm_i, intensity_i and last_beam_i. A word is taken when valid is
//    high and stall is low. A two-word queue sits behind the front part.
//  - Output channel (out_valid_o / out_stall_i): one word per beam with the
//    running segment_count_o and scan_end_o (set on the scan's last beam).
//  - Path: a beam leaves the queue in the idle state and reaches the output
//    register in the update state; a high beam first runs the one-stage-per-
//    cycle CORDIC rotation, then the rounding and squaring steps.
//  - The back part takes one beam at a time: the next leaves the queue only
//    after the last has passed its update step; one CORDIC unit is shared.
//  - Config port: cfg_we_i, cfg_idx_i, cfg_data_i; index 0 start angle (also
//    reloads the beam angle), 1 angle step, 2 intensity threshold, 3 join
//    distance. Other indexes are ignored. Write only while idle.
//  - Reset: registers return to defaults, beam angle to the start angle,
//    run state and count cleared, queue and output register empty.
//  - Output stall: the result register holds its word; the back part waits,
//    then the queue fills and in_stall_o rises.
`default_nettype none
module lidar_reflector_segment_counter_top #(
  parameter int unsigned MAX_BEAMS     = lrsc_pkg::DefMaxBeams,
  parameter int unsigned CORDIC_STAGES = lrsc_pkg::DefCordicStages
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] range_mm_i,
  input  wire logic [15:0] intensity_i,
  input  wire logic        last_beam_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [10:0]      segment_count_o,
  output logic             scan_end_o
);
  import lrsc_pkg::*;

  `include "lidar_reflector_segment_counter_top_assert.svh"

  localparam int unsigned CountCap = (MAX_BEAMS / 2 < 1024) ? MAX_BEAMS / 2 : 1024;

  cfg_t  cfg_q, cfg_d;
  beam_t q_wdata, q_rdata;
  logic  q_push, q_pop, q_full, q_empty;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartAngle: cfg_d.start_angle = cfg_data_i;
        RegAngleStep:  cfg_d.angle_step  = cfg_data_i;
        RegThreshold:  cfg_d.threshold   = cfg_data_i;
        RegJoinDist:   cfg_d.join_dist   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= 16'd0;
      cfg_q.angle_step  <= 16'd64;
      cfg_q.threshold   <= 16'd32768;
      cfg_q.join_dist   <= 16'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lrsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .range_mm_i  (range_mm_i),
    .intensity_i (intensity_i),
    .last_beam_i (last_beam_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lrsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  lrsc_back #(
    .MAX_BEAMS     (MAX_BEAMS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .segment_count_o (segment_count_o),
    .scan_end_o      (scan_end_o)
  );

  // Queue must never be written when full nor read when empty.
  `LRSC_ASSERT_ALWAYS(a_no_overflow, clk_i, !(q_push && q_full))
  `LRSC_ASSERT(a_no_underflow, clk_i, rst_ni, !(q_pop && q_empty))
  // Reported count never passes the cap.
  `LRSC_ASSERT(a_count_cap, clk_i, rst_ni, out_valid_o |-> (segment_count_o <= 11'(CountCap)))

endmodule
`default_nettype wire

// File: src/lrsc_queue.sv
// Two-entry word queue between the front and back parts.
`default_nettype none
module lrsc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lrsc_pkg::beam_t push_data_i,
  input  wire logic           pop_i,
  output lrsc_pkg::beam_t     pop_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import lrsc_pkg::*;

  beam_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o     = fill_q[1];
  assign empty_o    = (fill_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/lrsc_front.sv
// Front part: takes beams, tracks the beam angle and classifies intensity.
`default_nettype none
module lrsc_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lrsc_pkg::cfg_t          cfg_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [lrsc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0]             cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [15:0]             range_mm_i,
  input  wire logic [15:0]             intensity_i,
  input  wire logic                    last_beam_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output lrsc_pkg::beam_t              q_data_o
);
  import lrsc_pkg::*;

  logic [AngleW-1:0] angle_q, angle_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.range_mm = range_mm_i;
    q_data_o.angle    = angle_q;
    q_data_o.high     = (intensity_i > cfg_i.threshold);
    q_data_o.last     = last_beam_i;
  end

  always_comb begin
    angle_d = angle_q;
    if (cfg_we_i && cfg_idx_i == RegStartAngle) begin
      angle_d = cfg_data_i;
    end else if (q_push_o) begin
      angle_d = last_beam_i ? cfg_i.start_angle : angle_q + cfg_i.angle_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else begin
      angle_q <= angle_d;
    end
  end

endmodule
`default_nettype wire

// File: src/lrsc_back.sv
// Back part: iterative CORDIC, distance test, run tracking and result register.
`default_nettype none
module lrsc_back #(
  parameter int unsigned MAX_BEAMS     = lrsc_pkg::DefMaxBeams,
  parameter int unsigned CORDIC_STAGES = lrsc_pkg::DefCordicStages
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lrsc_pkg::cfg_t  cfg_i,
  input  wire logic            q_empty_i,
  input  wire lrsc_pkg::beam_t q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [10:0]          segment_count_o,
  output logic                 scan_end_o
);
  import lrsc_pkg::*;

  localparam int unsigned NStages  = (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;
  localparam int unsigned CountCap = (MAX_BEAMS / 2 < 1024) ? MAX_BEAMS / 2 : 1024;
  localparam logic [StageIdxW-1:0] LastStage = StageIdxW'(NStages - 1);
  localparam logic [CountW-1:0]    CapVal    = CountW'(CountCap);

  back_state_e state_q, state_d;

  beam_t                  beam_q;
  logic signed [AccW-1:0] x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic [StageIdxW-1:0]   i_q;
  logic signed [XyW-1:0]  xm_q, ym_q;
  logic [37:0]            dxx_q, dyy_q;

  logic                   run_active_q;
  logic [RunW-1:0]        run_len_q;
  logic signed [XyW-1:0]  sx_q, sy_q;
  logic [CountW-1:0]      count_q;
  logic                   out_valid_q;
  logic [CountW-1:0]      out_count_q;
  logic                   out_end_q;

  logic                   out_free;
  logic                   upd_go;

  // datapath helpers
  logic                   flip;
  logic [31:0]            prod;
  logic signed [AccW-1:0] x0;
  logic signed [AccW-1:0] xs, ys;
  logic signed [ZW-1:0]   at;
  logic signed [19:0]     xr, yr;
  logic signed [XyW-1:0]  xc, yc;
  logic signed [18:0]     dx, dy;
  logic signed [37:0]     dx2, dy2;
  logic [38:0]            d2;
  logic [31:0]            j2;
  logic                   joins;
  logic [RunW-1:0]        len_inc;
  logic                   bump;
  logic [CountW-1:0]      cnt_next;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign upd_go      = (state_q == StUpdate) && out_free;
  assign out_valid_o = out_valid_q;
  assign segment_count_o = out_count_q;
  assign scan_end_o  = out_end_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (!q_empty_i) state_d = q_data_i.high ? StRot : StUpdate;
      StRot:    if (i_q == LastStage) state_d = StRound;
      StRound:  state_d = StSquare;
      StSquare: state_d = StUpdate;
      StUpdate: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o = 1'b0;
    case (state_q)
      StIdle:  q_pop_o = !q_empty_i;
      default: q_pop_o = 1'b0;
    endcase
  end

  // rotation, rounding, distance and count arithmetic
  always_comb begin
    flip = q_data_i.angle[15] ^ q_data_i.angle[14];
    prod = 32'(q_data_i.range_mm) * 32'(KinvQ16);
    x0   = flip ? -$signed({4'b0, prod}) : $signed({4'b0, prod});
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    at   = $signed({2'b0, atan_turn(i_q)});
    xr   = 20'((x_q + AccW'(32768)) >>> 16);
    yr   = 20'((y_q + AccW'(32768)) >>> 16);
    xc   = (xr > 20'sd131071) ? 18'sh1FFFF :
           (xr < -20'sd131072) ? 18'sh20000 : xr[XyW-1:0];
    yc   = (yr > 20'sd131071) ? 18'sh1FFFF :
           (yr < -20'sd131072) ? 18'sh20000 : yr[XyW-1:0];
    dx   = {xm_q[XyW-1], xm_q} - {sx_q[XyW-1], sx_q};
    dy   = {ym_q[XyW-1], ym_q} - {sy_q[XyW-1], sy_q};
    dx2  = dx * dx;
    dy2  = dy * dy;
    d2   = {1'b0, dxx_q} + {1'b0, dyy_q};
    j2   = 32'(cfg_i.join_dist) * 32'(cfg_i.join_dist);
    joins = d2 < {7'b0, j2};
    len_inc = (run_len_q < RunW'(RunMax)) ? run_len_q + 1'b1 : run_len_q;
    // a run is counted once, when it reaches two beams
    bump = beam_q.high && run_active_q && joins && (len_inc == RunW'(2)) &&
           (count_q < CapVal);
    cnt_next = bump ? count_q + 1'b1 : count_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          beam_q <= q_data_i;
          x_q    <= x0;
          y_q    <= '0;
          z_q    <= ZW'($signed({q_data_i.angle[15] ^ flip, q_data_i.angle[14:0], 16'b0}));
          i_q    <= '0;
        end
      end
      StRot: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
      end
      StRound: begin
        xm_q <= xc;
        ym_q <= yc;
      end
      StSquare: begin
        dxx_q <= dx2[37:0];
        dyy_q <= dy2[37:0];
      end
      default: ;
    endcase
  end

  // run state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      run_active_q <= 1'b0;
      run_len_q    <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_count_q  <= '0;
      out_end_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_go) begin
        out_valid_q <= 1'b1;
        out_count_q <= cnt_next;
        out_end_q   <= beam_q.last;
        if (beam_q.last) begin
          run_active_q <= 1'b0;
          run_len_q    <= '0;
          sx_q         <= '0;
          sy_q         <= '0;
          count_q      <= '0;
        end else if (beam_q.high) begin
          count_q <= cnt_next;
          if (run_active_q && joins) begin
            run_len_q <= len_inc;
          end else begin
            run_active_q <= 1'b1;
            run_len_q    <= RunW'(1);
            sx_q         <= xm_q;
            sy_q         <= ym_q;
          end
        end else begin
          run_active_q <= 1'b0;
          run_len_q    <= '0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
